// ----- sv/ps2_mouse_packet_decoder_unit_defines.svh -----
// assertion macros used by the asserting file (the top-level decoder unit)
`ifndef PS2_MOUSE_PACKET_DECODER_UNIT_DEFINES_SVH
`define PS2_MOUSE_PACKET_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PS2MD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PS2MD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ps2md_pkg.sv -----
package ps2md_pkg;

    localparam int BTN_COUNT = 5;
    localparam int PKT_DEPTH = 3;
    localparam int TDATA_W   = 32;

    // packet modes
    localparam logic [1:0] MODE_STANDARD    = 2'd0;
    localparam logic [1:0] MODE_SCROLL      = 2'd1;
    localparam logic [1:0] MODE_FIVE_BUTTON = 2'd2;

    // event kinds
    localparam logic EVT_CURSOR = 1'b0;
    localparam logic EVT_BUTTON = 1'b1;

    typedef struct packed {
        logic                 event_kind;
        logic signed [8:0]    move_x;
        logic signed [8:0]    move_y;
        logic signed [7:0]    move_z;
        logic [2:0]           button_index;
        logic                 released;
        logic                 last_of_run;
    } result_t;

    // everything the decoder hands back for one byte
    typedef struct packed {
        logic [1:0]           pos_next;
        logic                 store_en;
        logic [1:0]           store_idx;
        logic [BTN_COUNT-1:0] pressed_next;
        logic [1:0]           res_cnt;
        result_t              res0;
        result_t              res1;
    } dec_t;

    function automatic logic [2:0] lowest_set(input logic [BTN_COUNT-1:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = BTN_COUNT - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- sv/ps2md_decode.sv -----
module ps2md_decode (
    input  logic [1:0]                                packet_mode,
    input  logic [7:0]                                data_byte,
    input  logic [1:0]                                byte_pos,
    input  logic [ps2md_pkg::PKT_DEPTH-1:0][7:0]      pkt_bytes,
    input  logic [ps2md_pkg::BTN_COUNT-1:0]           pressed,
    output ps2md_pkg::dec_t                           dec
);

    logic                             wide;
    logic [1:0]                       last_pos;
    logic [7:0]                       b0, b1, b2, b3;
    logic signed [8:0]                mx, my;
    logic signed [7:0]                mz;
    logic                             moved;
    logic [ps2md_pkg::BTN_COUNT-1:0]  buttons, changed;
    ps2md_pkg::result_t               cur_ev, btn_ev;

    always_comb begin
        wide     = (packet_mode == ps2md_pkg::MODE_SCROLL) ||
                   (packet_mode == ps2md_pkg::MODE_FIVE_BUTTON);
        last_pos = wide ? 2'd3 : 2'd2;

        b0 = pkt_bytes[0];
        b1 = pkt_bytes[1];
        b2 = wide ? pkt_bytes[2] : data_byte;
        b3 = wide ? data_byte : 8'h00;

        mx = {b0[4], b1};
        my = {b0[5], b2};
        case (packet_mode)
            ps2md_pkg::MODE_SCROLL:      mz = b3;
            ps2md_pkg::MODE_FIVE_BUTTON: mz = {{4{b3[3]}}, b3[3:0]};
            default:                     mz = 8'sd0;
        endcase
        moved = (mx != 9'sd0) || (my != 9'sd0) || (mz != 8'sd0);

        buttons = {(packet_mode == ps2md_pkg::MODE_FIVE_BUTTON) ? b3[5:4] : 2'b00, b0[2:0]};
        changed = buttons ^ pressed;

        cur_ev              = '0;
        cur_ev.event_kind   = ps2md_pkg::EVT_CURSOR;
        cur_ev.move_x       = mx;
        cur_ev.move_y       = my;
        cur_ev.move_z       = mz;
        cur_ev.last_of_run  = (changed == '0);

        btn_ev              = '0;
        btn_ev.event_kind   = ps2md_pkg::EVT_BUTTON;
        btn_ev.move_x       = moved ? mx : 9'sd0;
        btn_ev.move_y       = moved ? my : 9'sd0;
        btn_ev.move_z       = moved ? mz : 8'sd0;
        btn_ev.button_index = ps2md_pkg::lowest_set(changed);
        btn_ev.released     = |(changed & pressed);
        btn_ev.last_of_run  = 1'b1;

        dec              = '0;
        dec.pressed_next = pressed;
        dec.store_idx    = byte_pos;
        if (byte_pos < last_pos) begin
            // header or middle byte: just hold it
            dec.store_en = 1'b1;
            dec.pos_next = byte_pos + 2'd1;
        end else begin
            dec.pos_next     = 2'd0;
            dec.pressed_next = buttons;
            dec.res_cnt      = {1'b0, moved} + {1'b0, (changed != '0)};
            if (moved) begin
                dec.res0 = cur_ev;
                dec.res1 = btn_ev;
            end else begin
                dec.res0 = btn_ev;
                dec.res1 = btn_ev;
            end
        end
    end

endmodule

// ----- sv/ps2md_queue.sv -----
module ps2md_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [1:0]          push_cnt,
    input  ps2md_pkg::result_t  push0,
    input  ps2md_pkg::result_t  push1,
    input  logic                pop,
    output ps2md_pkg::result_t  head,
    output logic [1:0]          count
);

    ps2md_pkg::result_t q_reg [2];
    logic               rd_reg, rd_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               wr_ptr;

    always_comb begin
        wr_ptr   = rd_reg ^ cnt_reg[0];
        rd_next  = rd_reg ^ pop;
        cnt_next = 2'(cnt_reg + push_cnt - {1'b0, pop});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // payload slots, no reset
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            q_reg[wr_ptr] <= push0;
        end
        if (push_cnt == 2'd2) begin
            q_reg[~wr_ptr] <= push1;
        end
    end

    assign head  = q_reg[rd_reg];
    assign count = cnt_reg;

endmodule

// ----- sv/ps2_mouse_packet_decoder_unit.sv -----
// ps/2 mouse packet decoder. raw mouse bytes come in on the s_ channel, one per transfer, and are
// framed into packets by position only: 3 bytes in standard mode (packet_mode 0, and the unused
// code 3), 4 bytes in scroll mode (1) and five-button mode (2). the byte that completes a packet
// yields a cursor event when any of dx, dy or wheel is nonzero, then a button event when the
// button set differs from the one last reported; tlast marks the final result of that byte, and
// bytes that yield nothing produce no transfer. timing: one byte is accepted every cycle; a
// result is offered on the m_ side once its byte has passed the input register and been
// decoded into the result queue. the two-entry result queue sets the pace: a packet giving two
// events needs two output transfers, and input stalls only while the queue cannot take the decoded
// results. packet_mode is written through cfg_wr_en / cfg_wr_data and must only change while idle.

`include "ps2_mouse_packet_decoder_unit_defines.svh"

module ps2_mouse_packet_decoder_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_wr_data,   // packet_mode
    // byte input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,       // [7:0] data_byte
    // event output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ps2md_pkg::TDATA_W-1:0]   m_tdata,       // [8:0] move_x, [17:9] move_y,
                                                           // [25:18] move_z,
                                                           // [28:26] button_index,
                                                           // [29] released, [31:30] zero
    output logic                            m_tuser,       // event_kind
    output logic                            m_tlast        // last_of_run
);

    // configuration register
    logic [1:0]                                 mode_reg;

    // input stage
    logic                                       in_valid_reg, in_valid_next;
    logic [7:0]                                 in_byte_reg;

    // packet framing state
    logic [1:0]                                 pos_reg;
    logic [ps2md_pkg::PKT_DEPTH-1:0][7:0]       pkt_reg;
    logic [ps2md_pkg::BTN_COUNT-1:0]            pressed_reg;

    ps2md_pkg::dec_t                            dec;
    ps2md_pkg::result_t                         head;
    logic [1:0]                                 q_count;
    logic [1:0]                                 q_free;
    logic                                       pop;
    logic                                       fire;
    logic [1:0]                                 push_cnt;

    // decode of the byte held in the input register
    ps2md_decode u_decode (
        .packet_mode (mode_reg),
        .data_byte   (in_byte_reg),
        .byte_pos    (pos_reg),
        .pkt_bytes   (pkt_reg),
        .pressed     (pressed_reg),
        .dec         (dec)
    );

    // result queue, doubles as the output register
    ps2md_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .push0    (dec.res0),
        .push1    (dec.res1),
        .pop      (pop),
        .head     (head),
        .count    (q_count)
    );

    always_comb begin
        pop      = m_tvalid && m_tready;
        // room left once this cycle's output transfer is taken out
        q_free   = 2'(2'd2 - q_count + {1'b0, pop});
        // held byte retires when its results all fit
        fire     = in_valid_reg && (dec.res_cnt <= q_free);
        push_cnt = fire ? dec.res_cnt : 2'd0;
        s_tready = !in_valid_reg || fire;
        in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= ps2md_pkg::MODE_STANDARD;
            in_valid_reg <= 1'b0;
            pos_reg      <= 2'd0;
            pressed_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            in_valid_reg <= in_valid_next;
            if (fire) begin
                pos_reg     <= dec.pos_next;
                pressed_reg <= dec.pressed_next;
            end
        end
    end

    // payload: input byte and held packet bytes, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (fire && dec.store_en) begin
            pkt_reg[dec.store_idx] <= in_byte_reg;
        end
    end

    // output packing
    assign m_tvalid = (q_count != 2'd0);
    assign m_tdata  = {2'b00, head.released, head.button_index, head.move_z,
                       head.move_y, head.move_x};
    assign m_tuser  = head.event_kind;
    assign m_tlast  = head.last_of_run;

    // queue never holds more than its two slots
    `PS2MD_ASSERT_NOW(a_queue_bound, 1'b1, q_count != 2'd3, "result queue overflow")
    // only a cursor event can be followed by another result of the same byte
    `PS2MD_ASSERT_NOW(a_nonlast_is_cursor, m_tvalid && !m_tlast,
                      m_tuser == ps2md_pkg::EVT_CURSOR, "non-final result is not a cursor event")
    // the button event of the same packet is waiting right behind the cursor event
    `PS2MD_ASSERT_NEXT(a_pair_follows, pop && !m_tlast,
                       m_tvalid && m_tuser == ps2md_pkg::EVT_BUTTON, "paired button event missing")

endmodule
